@@ design/ssps_pkg.sv @@
// Package for the state-space plant step core: sizes, fixed-point formats and
// the structs passed between the sequencer and the multiply-accumulate unit.
// No dependencies.
package ssps_pkg;

    localparam int ORDER      = 6;
    localparam int COEF_FRAC  = 28;
    localparam int STATE_FRAC = 16;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 6;
    localparam int COEF_COUNT = ORDER * ORDER + ORDER;
    localparam int COEF_AW    = (COEF_COUNT > 1) ? $clog2(COEF_COUNT) : 1;
    localparam int ROW_W      = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int COL_W      = $clog2(ORDER + 1);
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + $clog2(ORDER + 1) + 1;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [ROW_W-1:0] row;
    } t_mac_tag;

    typedef struct packed {
        logic                     vld;
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } t_mac_res;

endpackage

@@ design/ssps_if.sv @@
// Valid/ready channel interfaces for the plant step core: one for input
// transactions and one for results. Depends on ssps_pkg.
interface ssps_in_if;
    import ssps_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [IDX_W-1:0]         coef_index;
    logic signed [DATA_W-1:0] coef_value;
    logic signed [DATA_W-1:0] drive_in;

    modport source (output valid, output cmd, output coef_index, output coef_value,
                    output drive_in, input ready);
    modport sink   (input valid, input cmd, input coef_index, input coef_value,
                    input drive_in, output ready);
endinterface

interface ssps_out_if;
    import ssps_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] plant_output;
    logic                     overflow;

    modport source (output valid, output plant_output, output overflow, input ready);
    modport sink   (input valid, input plant_output, input overflow, output ready);
endinterface

@@ design/ssps_coef_ram.sv @@
// Coefficient memory with one write port and one registered read port.
// Per-entry valid bits make never-written entries read as zero. Depends on ssps_pkg.
module ssps_coef_ram (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [ssps_pkg::COEF_AW-1:0]       i_wr_addr,
    input  logic signed [ssps_pkg::DATA_W-1:0] i_wr_data,
    input  logic [ssps_pkg::COEF_AW-1:0]       i_rd_addr,
    output logic signed [ssps_pkg::DATA_W-1:0] o_rd_data
);
    import ssps_pkg::*;

    logic signed [DATA_W-1:0] r_mem [COEF_COUNT];
    logic [COEF_COUNT-1:0]    r_valid;
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ design/ssps_mac.sv @@
// Shared multiply-accumulate unit: a registered 32x32 product, a wide
// accumulator, then rounding and saturation to Q16.16. Depends on ssps_pkg.
module ssps_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssps_pkg::t_mac_tag                 i_tag,
    input  logic signed [ssps_pkg::DATA_W-1:0] i_coef,
    input  logic signed [ssps_pkg::DATA_W-1:0] i_oper,
    output ssps_pkg::t_mac_res                 o_res
);
    import ssps_pkg::*;

    localparam logic signed [ACC_W-1:0] RND =
        {{(ACC_W - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    t_mac_tag                 r_p_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_a_done;
    logic [ROW_W-1:0]         r_a_row;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_sh;
    t_mac_res                 r_res;

    assign w_prod_ext = ACC_W'(r_prod);
    assign w_rnd      = r_acc + RND;
    assign w_sh       = w_rnd >>> COEF_FRAC;

    always_ff @(posedge i_clk) begin
        r_prod  <= i_coef * i_oper;
        r_a_row <= r_p_tag.row;
        if (r_p_tag.vld) begin
            r_acc <= r_p_tag.first ? w_prod_ext : r_acc + w_prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_tag   <= '0;
            r_a_done  <= 1'b0;
            r_res.vld <= 1'b0;
        end else begin
            r_p_tag   <= i_tag;
            r_a_done  <= r_p_tag.vld && r_p_tag.last;
            r_res.vld <= r_a_done;
            r_res.row <= r_a_row;
            if (w_sh > SAT_HI) begin
                r_res.value <= SAT_HI[DATA_W-1:0];
                r_res.sat   <= 1'b1;
            end else if (w_sh < SAT_LO) begin
                r_res.value <= SAT_LO[DATA_W-1:0];
                r_res.sat   <= 1'b1;
            end else begin
                r_res.value <= w_sh[DATA_W-1:0];
                r_res.sat   <= 1'b0;
            end
        end
    end

    assign o_res = r_res;

endmodule

@@ design/state_space_plant_step_core.sv @@
// State-space plant step core, top level: sequencer, state registers and result register.
// A step transaction streams 42 multiply-accumulates through the one shared multiplier;
// no new transaction is accepted until the result is loaded into the result register.
// Synchronous active-low reset zeroes the states, marks every coefficient as zero
// and leaves the core idle with no result pending.
// Depends on ssps_pkg, ssps_if, ssps_coef_ram and ssps_mac.
module state_space_plant_step_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssps_in_if.sink   i_in,
    ssps_out_if.source o_out
);
    import ssps_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ORDER - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(ORDER);

    logic [1:0]               r_st;
    logic [1:0]               n_st;
    logic                     r_issue;
    logic [ROW_W-1:0]         r_row;
    logic [COL_W-1:0]         r_col;
    logic signed [DATA_W-1:0] r_state [ORDER];
    logic signed [DATA_W-1:0] r_next [ORDER];
    logic signed [DATA_W-1:0] r_drive;
    logic signed [DATA_W-1:0] r_oper;
    logic                     r_sat;
    t_mac_tag                 r_rd_tag;
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_val;
    logic                     r_out_ovf;

    logic                     w_in_acc;
    logic                     w_step_go;
    logic                     w_wr_en;
    logic                     w_issue_last;
    logic                     w_out_free;
    logic [COEF_AW-1:0]       w_rd_addr;
    logic signed [DATA_W-1:0] w_coef;
    t_mac_res                 w_res;

    assign i_in.ready   = (r_st == ST_IDLE);
    assign w_in_acc     = i_in.valid && i_in.ready;
    assign w_step_go    = w_in_acc && !i_in.cmd;
    assign w_wr_en      = w_in_acc && i_in.cmd &&
                          ({1'b0, i_in.coef_index} < (IDX_W + 1)'(COEF_COUNT));
    assign w_issue_last = (r_row == ROW_LAST) && (r_col == COL_LAST);
    assign w_out_free   = !r_out_vld || o_out.ready;

    always_comb begin
        if (r_col < COL_LAST) begin
            w_rd_addr = COEF_AW'(int'(r_row) * ORDER + int'(r_col));
        end else begin
            w_rd_addr = COEF_AW'(ORDER * ORDER + int'(r_row));
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_step_go) n_st = ST_RUN;
            end
            ST_RUN: begin
                if (w_res.vld && w_res.row == ROW_LAST) n_st = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (w_out_free) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    ssps_coef_ram u_coef_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (COEF_AW'(i_in.coef_index)),
        .i_wr_data (i_in.coef_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_coef)
    );

    ssps_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_coef  (w_coef),
        .i_oper  (r_oper),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_step_go) begin
            r_drive <= i_in.drive_in;
        end
        if (r_col < COL_LAST) begin
            r_oper <= r_state[r_col[ROW_W-1:0]];
        end else begin
            r_oper <= r_drive;
        end
        if (w_res.vld) begin
            r_next[w_res.row] <= w_res.value;
        end
        if (r_st == ST_COMMIT && w_out_free) begin
            r_out_val <= r_next[ORDER-1];
            r_out_ovf <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_issue   <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_sat     <= 1'b0;
            r_rd_tag  <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < ORDER; i++) begin
                r_state[i] <= '0;
            end
        end else begin
            r_st <= n_st;

            r_rd_tag.vld   <= r_issue;
            r_rd_tag.first <= (r_col == '0);
            r_rd_tag.last  <= (r_col == COL_LAST);
            r_rd_tag.row   <= r_row;

            if (w_step_go) begin
                r_issue <= 1'b1;
                r_row   <= '0;
                r_col   <= '0;
                r_sat   <= 1'b0;
            end else if (r_issue) begin
                if (w_issue_last) begin
                    r_issue <= 1'b0;
                end
                if (r_col == COL_LAST) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end

            if (w_res.vld && w_res.sat) begin
                r_sat <= 1'b1;
            end

            if (r_st == ST_COMMIT && w_out_free) begin
                r_out_vld <= 1'b1;
                for (int i = 0; i < ORDER; i++) begin
                    r_state[i] <= r_next[i];
                end
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.plant_output = r_out_val;
    assign o_out.overflow     = r_out_ovf;

endmodule
